[rtl/sync_length_tail_deframer_top_assert.svh]
// Assertion macros for the sync/length/tail deframer.
`ifndef SYNC_LENGTH_TAIL_DEFRAMER_TOP_ASSERT_SVH
`define SYNC_LENGTH_TAIL_DEFRAMER_TOP_ASSERT_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define SLTD_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("deframer check failed");

// Next-cycle implication.
`define SLTD_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("deframer check failed");

`endif

[rtl/sltd_pkg.sv]
// Shared types and codes for the sync/length/tail deframer.
package sltd_pkg;

   localparam int unsigned CSR_IDX_W = 1;
   localparam int unsigned CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_SYNC_WORD = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TAIL_WORD = 1'd1;

   localparam logic [31:0] SYNC_WORD_RESET = 32'h0FF0_00FF;
   localparam logic [15:0] TAIL_WORD_RESET = 16'h0D0A;

   localparam logic [1:0] KIND_DATA = 2'd0;
   localparam logic [1:0] KIND_GOOD = 2'd1;
   localparam logic [1:0] KIND_DROP = 2'd2;

   typedef struct packed {
      logic [31:0] sync_word;
      logic [15:0] tail_word;
   } sltd_cfg_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  frame_type;
      logic [7:0]  data_byte;
      logic [15:0] byte_index;
      logic [15:0] frame_length;
      logic        last_payload;
   } sltd_result_type;

endpackage

[rtl/sltd_csr.sv]
// Configuration registers: sync word and tail word.
module sltd_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [sltd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [sltd_pkg::CSR_DATA_W-1:0] csr_data,
   output sltd_pkg::sltd_cfg_type          cfg
);
   import sltd_pkg::*;

   sltd_cfg_type cfg_ff;
   sltd_cfg_type cfg_in;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_SYNC_WORD: cfg_in.sync_word = csr_data[31:0];
            CSR_TAIL_WORD: cfg_in.tail_word = csr_data[15:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sync_word <= SYNC_WORD_RESET;
         cfg_ff.tail_word <= TAIL_WORD_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[rtl/sltd_in_stage.sv]
// Input register for received bytes.
module sltd_in_stage (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       out_free,
   output logic       item_valid,
   output logic [7:0] item_byte,
   output logic       item_fire
);
   import sltd_pkg::*;

   logic       valid_ff;
   logic       valid_in;
   logic [7:0] byte_ff;
   logic       accept;

   assign item_fire = valid_ff && out_free;
   assign req_stall = valid_ff && !out_free;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      if (accept) begin
         valid_in = 1'b1;
      end else if (item_fire) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         byte_ff <= req_in_byte;
      end
   end

   assign item_valid = valid_ff;
   assign item_byte  = byte_ff;

endmodule

[rtl/sltd_core.sv]
// Frame state machine: sync hunt, header, payload and tail check.
module sltd_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          item_fire,
   input  logic [7:0]                    item_byte,
   input  sltd_pkg::sltd_cfg_type        cfg,
   output logic                          res_valid,
   output sltd_pkg::sltd_result_type     res
);
   import sltd_pkg::*;

   localparam logic [2:0] PH_HUNT    = 3'd0;
   localparam logic [2:0] PH_LEN_HI  = 3'd1;
   localparam logic [2:0] PH_LEN_LO  = 3'd2;
   localparam logic [2:0] PH_TYPE    = 3'd3;
   localparam logic [2:0] PH_PAYLOAD = 3'd4;
   localparam logic [2:0] PH_TAIL1   = 3'd5;
   localparam logic [2:0] PH_TAIL2   = 3'd6;

   logic [2:0]  phase_ff,  phase_in;
   logic [1:0]  fill_ff,   fill_in;
   logic [23:0] recent_ff, recent_in;
   logic [15:0] len_ff,    len_in;
   logic [15:0] cnt_ff,    cnt_in;
   logic [7:0]  type_ff,   type_in;
   logic [7:0]  tail1_ff,  tail1_in;

   logic [31:0] window;
   logic [16:0] cnt_next;
   logic        last;

   assign window   = {recent_ff, item_byte};
   assign cnt_next = {1'b0, cnt_ff} + 17'd1;
   assign last     = (cnt_next == {1'b0, len_ff});

   always_comb begin
      phase_in  = phase_ff;
      fill_in   = fill_ff;
      recent_in = recent_ff;
      len_in    = len_ff;
      cnt_in    = cnt_ff;
      type_in   = type_ff;
      tail1_in  = tail1_ff;

      res_valid        = 1'b0;
      res.kind         = KIND_DATA;
      res.frame_type   = type_ff;
      res.data_byte    = 8'd0;
      res.byte_index   = 16'd0;
      res.frame_length = len_ff;
      res.last_payload = 1'b0;

      if (item_fire) begin
         case (phase_ff)
            PH_HUNT: begin
               if (fill_ff == 2'd3 && window == cfg.sync_word) begin
                  phase_in  = PH_LEN_HI;
                  recent_in = 24'd0;
                  fill_in   = 2'd0;
               end else begin
                  recent_in = window[23:0];
                  if (fill_ff != 2'd3) begin
                     fill_in = fill_ff + 2'd1;
                  end
               end
            end
            PH_LEN_HI: begin
               len_in   = {item_byte, 8'h00};
               phase_in = PH_LEN_LO;
            end
            PH_LEN_LO: begin
               len_in   = {len_ff[15:8], item_byte};
               phase_in = PH_TYPE;
            end
            PH_TYPE: begin
               type_in  = item_byte;
               cnt_in   = 16'd0;
               phase_in = (len_ff == 16'd0) ? PH_TAIL1 : PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
               res_valid        = 1'b1;
               res.kind         = KIND_DATA;
               res.data_byte    = item_byte;
               res.byte_index   = cnt_ff;
               res.last_payload = last;
               if (last) begin
                  phase_in = PH_TAIL1;
               end else begin
                  cnt_in = cnt_next[15:0];
               end
            end
            PH_TAIL1: begin
               tail1_in = item_byte;
               phase_in = PH_TAIL2;
            end
            PH_TAIL2: begin
               res_valid = 1'b1;
               res.kind  = ({tail1_ff, item_byte} == cfg.tail_word) ? KIND_GOOD : KIND_DROP;
               phase_in  = PH_HUNT;
               recent_in = 24'd0;
               fill_in   = 2'd0;
            end
            default: begin
               phase_in  = PH_HUNT;
               recent_in = 24'd0;
               fill_in   = 2'd0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         fill_ff  <= 2'd0;
      end else begin
         phase_ff <= phase_in;
         fill_ff  <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      recent_ff <= recent_in;
      len_ff    <= len_in;
      cnt_ff    <= cnt_in;
      type_ff   <= type_in;
      tail1_ff  <= tail1_in;
   end

endmodule

[rtl/sltd_out_stage.sv]
// Result register toward the response channel.
module sltd_out_stage (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      load,
   input  sltd_pkg::sltd_result_type load_res,
   input  logic                      rsp_stall,
   output logic                      rsp_valid,
   output sltd_pkg::sltd_result_type rsp_res,
   output logic                      out_free
);
   import sltd_pkg::*;

   logic            valid_ff;
   logic            valid_in;
   sltd_result_type res_ff;

   assign out_free = !valid_ff || !rsp_stall;

   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_stall) begin
         valid_in = valid_ff;
      end else begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         res_ff <= load_res;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_res   = res_ff;

endmodule

[rtl/sync_length_tail_deframer_top.sv]
// Top level of the sync/length/tail deframer.
//
// Byte-stream deframer. Frames look like sync (4 bytes, first byte most
// significant in csr sync_word) | length (2 bytes, big-endian) | type (1 byte)
// | payload (length bytes) | tail (2 bytes, compared with csr tail_word).
// While hunting, a 4-byte window slides over the stream one byte at a time;
// a match needs four real bytes since reset or since the last frame ended.
// Each payload byte comes out as one response with kind DATA, its index,
// the frame type and length, and last_payload set on the final byte. After
// the second tail byte one response reports GOOD or DROP, then the hunt
// restarts with an empty window. Header and tail bytes give no response; a
// zero-length frame gives only its GOOD or DROP report. The length is not
// range checked.
// Throughput: one request per clock while req_stall is low. A request waits
// in the input register, then the state machine decides its response in one
// combinational step and loads the result register once that register is
// free, and the response is then on the rsp_ ports. The result register lets
// a new request move forward while the previous response is still waiting;
// rsp_stall reaches req_stall only once both registers are full.
// Configuration: csr index 0 is sync_word, 1 is tail_word; csr_ready is
// always high. Write only while no request is in flight.
module sync_length_tail_deframer_top (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [7:0]                      req_in_byte,
   // response channel
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [1:0]                      rsp_kind,
   output logic [7:0]                      rsp_frame_type,
   output logic [7:0]                      rsp_data_byte,
   output logic [15:0]                     rsp_byte_index,
   output logic [15:0]                     rsp_frame_length,
   output logic                            rsp_last_payload,
   // configuration writes
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [sltd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [sltd_pkg::CSR_DATA_W-1:0] csr_data
);
   import sltd_pkg::*;

   sltd_cfg_type    cfg;
   logic            out_free;
   logic            item_valid;
   logic [7:0]      item_byte;
   logic            item_fire;
   logic            res_valid;
   sltd_result_type res;
   sltd_result_type rsp_res;

   sltd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // Input register: holds one request until the result register can take
   // whatever it produces.
   sltd_in_stage u_in (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_in_byte (req_in_byte),
      .out_free    (out_free),
      .item_valid  (item_valid),
      .item_byte   (item_byte),
      .item_fire   (item_fire)
   );

   // Frame state advances only on item_fire, so a stalled byte is never
   // consumed twice.
   sltd_core u_core (
      .clock     (clock),
      .reset     (reset),
      .item_fire (item_fire),
      .item_byte (item_byte),
      .cfg       (cfg),
      .res_valid (res_valid),
      .res       (res)
   );

   sltd_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (res_valid),
      .load_res  (res),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_res   (rsp_res),
      .out_free  (out_free)
   );

   assign rsp_kind         = rsp_res.kind;
   assign rsp_frame_type   = rsp_res.frame_type;
   assign rsp_data_byte    = rsp_res.data_byte;
   assign rsp_byte_index   = rsp_res.byte_index;
   assign rsp_frame_length = rsp_res.frame_length;
   assign rsp_last_payload = rsp_res.last_payload;

`include "sync_length_tail_deframer_top_assert.svh"

   // a result is only produced from a byte that actually moved
   `SLTD_ASSERT_NOW(a_res_needs_fire, res_valid, item_fire && item_valid)
   // payload index always inside the announced length
   `SLTD_ASSERT_NOW(a_index_in_range, rsp_valid && rsp_kind == KIND_DATA,
                    rsp_byte_index < rsp_frame_length)
   // last flag only on payload bytes
   `SLTD_ASSERT_NOW(a_last_is_data, rsp_valid && rsp_last_payload, rsp_kind == KIND_DATA)
   // a held response keeps the request side blocked only if the input register is full
   `SLTD_ASSERT_NOW(a_stall_needs_item, req_stall, item_valid && rsp_valid && rsp_stall)

endmodule
